// ----- hw/rtl/plws_pkg.sv -----
// Package with shared types, constants and request codes of the waveform sequencer.
`timescale 1ns / 1ps
package plws_pkg;

  localparam int unsigned TableDepthDefault = 64;

  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRepeat = 2'd2;
  localparam logic [1:0] ReqIgnored = 2'd3;

  localparam logic [2:0] CfgMode    = 3'd0;
  localparam logic [2:0] CfgSteady  = 3'd1;
  localparam logic [2:0] CfgRipLow  = 3'd2;
  localparam logic [2:0] CfgRipHiT  = 3'd3;
  localparam logic [2:0] CfgRipLoT  = 3'd4;
  localparam logic [2:0] CfgDelay   = 3'd5;

  localparam logic [7:0] RepeatForever = 8'hff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  entry_index;
    logic [15:0] entry_time;
    logic [15:0] entry_value;
    logic [7:0]  repeat_count;
  } req_t;

  typedef struct packed {
    logic [15:0] dac_code;
    logic        dac_write;
    logic        range_out;
    logic        ripple_low_phase;
    logic [7:0]  repeats_left;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        negative;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

// ----- hw/rtl/plws_divider.sv -----
// Serial restoring divider that returns a signed truncated quotient of a 32-bit product.
`timescale 1ns / 1ps
module plws_divider
  import plws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  div_req_t     req_i,
  input  logic [31:0]  product_i,
  output logic         done_o,
  output logic [31:0]  quotient_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [15:0] den_q, den_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    num_d   = num_q;
    den_d   = den_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q[30:0], num_q[31]};
    trial   = {1'b0, shifted} - {17'd0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      quo_d  = '0;
      num_d  = product_i;
      den_d  = req_i.divisor;
      neg_d  = req_i.negative;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// ----- hw/rtl/piecewise_linear_waveform_sequencer.sv -----
// Top level of the piecewise linear waveform sequencer with table, control and sequencer.
// A steady or ripple tick goes from idle to StFin, which registers its result; a table tick
// passes StRd0, StEval and StChk, an interpolating tick also StRdNx and StDiv for the
// 32-step serial divider, and a tick that ends its segment also StNxt. One request is
// worked at a time, and no request is taken while a result waits. Reset clears all
// control state; the point table holds no reset value and must be written first.
`timescale 1ns / 1ps
module piecewise_linear_waveform_sequencer
  import plws_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRd0   = 3'd1;
  localparam logic [2:0] StEval  = 3'd2;
  localparam logic [2:0] StRdNx  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StChk   = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;
  localparam logic [2:0] StNxt   = 3'd7;

  logic [15:0] time_mem [TableDepth];
  logic [15:0] value_mem [TableDepth];
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_idx;
  logic [15:0] rd_time_q, rd_value_q;

  logic [3:0]  mode_q;
  logic [15:0] steady_q, riplow_q, delay_cfg_q;
  logic [14:0] riphi_t_q, riplo_t_q;

  logic [2:0]  state_q, state_d;
  logic [IdxW-1:0] seg_q, seg_d;
  logic [15:0] segt_q, segt_d, dly_q, dly_d, held_q, held_d, lastw_q, lastw_d;
  logic [7:0]  rep_q, rep_d;
  logic        rrun_q, rrun_d, rlow_q, rlow_d, rpin_q, rpin_d;
  logic signed [16:0] rcnt_q, rcnt_d;
  logic [1:0]  lrange_q, lrange_d;
  logic [2:0]  rstage_q, rstage_d;
  logic [15:0] t0_q, t0_d, v0_q, v0_d;
  logic        ovalid_q, ovalid_d;
  rsp_t        out_q, out_d;

  div_req_t    dreq;
  logic [31:0] dprod, dquo;
  logic        ddone;
  logic signed [16:0] diff;
  logic        allow;
  logic [IdxW-1:0] nxt_seg;
  logic [IdxW:0]   seg_inc;
  logic        accept;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    logic [IdxW:0] s;
    s = {1'b0, i} + 1'b1;
    return (s >= (IdxW+1)'(TableDepth)) ? '0 : s[IdxW-1:0];
  endfunction

  plws_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (dreq),
    .product_i  (dprod),
    .done_o     (ddone),
    .quotient_o (dquo)
  );

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == StIdle) && !ovalid_q;
  assign rsp_valid_o = ovalid_q;
  assign rsp_o       = out_q;
  assign seg_inc     = {1'b0, seg_q} + 1'b1;
  assign nxt_seg     = next_idx(seg_q);
  assign wr_idx      = IdxW'(req_i.entry_index);
  assign allow       = mode_q[2] && (riphi_t_q != '0) && (riplo_t_q != '0);
  assign diff        = $signed({1'b0, rd_value_q}) - $signed({1'b0, v0_q});
  assign dprod       = (diff[16] ? 32'(-diff) : 32'(diff)) * {16'd0, segt_q};

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == ReqWrite &&
        {26'd0, req_i.entry_index} < 32'(TableDepth)) begin
      time_mem[wr_idx]  <= req_i.entry_time;
      value_mem[wr_idx] <= req_i.entry_value;
    end
    rd_time_q  <= time_mem[rd_addr];
    rd_value_q <= value_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      steady_q    <= '0;
      riplow_q    <= '0;
      riphi_t_q   <= '0;
      riplo_t_q   <= '0;
      delay_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMode:   mode_q      <= cfg_data_i[3:0];
        CfgSteady: steady_q    <= cfg_data_i;
        CfgRipLow: riplow_q    <= cfg_data_i;
        CfgRipHiT: riphi_t_q   <= cfg_data_i[14:0];
        CfgRipLoT: riplo_t_q   <= cfg_data_i[14:0];
        CfgDelay:  delay_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    seg_d    = seg_q;
    segt_d   = segt_q;
    dly_d    = dly_q;
    held_d   = held_q;
    lastw_d  = lastw_q;
    rep_d    = rep_q;
    rrun_d   = rrun_q;
    rlow_d   = rlow_q;
    rpin_d   = rpin_q;
    rcnt_d   = rcnt_q;
    lrange_d = lrange_q;
    rstage_d = rstage_q;
    t0_d     = t0_q;
    v0_d     = v0_q;
    ovalid_d = ovalid_q && !rsp_ready_i;
    out_d    = out_q;
    rd_addr  = seg_q;
    dreq     = '{start: 1'b0, negative: diff[16], dividend: '0, divisor: t0_q};
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.req_type == ReqRepeat) begin
            rep_d = req_i.repeat_count;
          end else if (req_i.req_type == ReqTick) begin
            if (!rrun_q && allow) begin
              rrun_d = 1'b1;
              rcnt_d = 17'(riphi_t_q);
              rlow_d = 1'b0;
            end
            if (rrun_q && !allow) begin
              rrun_d = 1'b0;
              rcnt_d = '0;
              rlow_d = 1'b0;
            end
            if (rrun_d) begin
              if (rcnt_d <= 0) begin
                rlow_d = !rlow_d;
                rcnt_d = rlow_d ? 17'(riplo_t_q) : 17'(riphi_t_q);
              end
              rcnt_d = rcnt_d - 17'sd1;
            end
            if (lrange_q != {1'b0, mode_q[3]}) begin
              lrange_d = {1'b0, mode_q[3]};
              rstage_d = 3'd0;
            end
            if (rstage_d < 3'd2) begin
              held_d = '0;
              rstage_d = rstage_d + 3'd1;
              state_d = StFin;
            end else if (rstage_d < 3'd4) begin
              held_d = '0;
              rpin_d = lrange_d[0];
              rstage_d = rstage_d + 3'd1;
              state_d = StFin;
            end else if (!mode_q[1]) begin
              held_d = (rrun_d && rlow_d) ? riplow_q : steady_q;
              state_d = StFin;
            end else begin
              state_d = StRd0;
            end
          end
        end
      end
      StRd0: begin
        state_d = StEval;
      end
      StEval: begin
        t0_d = rd_time_q;
        v0_d = rd_value_q;
        if (rd_time_q == '0 || rep_q == '0) begin
          held_d = rd_value_q;
          segt_d = '0;
          seg_d  = '0;
          dly_d  = delay_cfg_q;
          if (rep_q != RepeatForever && rep_q != '0) rep_d = rep_q - 8'd1;
          rd_addr = '0;
          state_d = StChk;
        end else if (dly_q == '0) begin
          if (segt_q < rd_time_q) begin
            rd_addr = nxt_seg;
            state_d = StRdNx;
          end else begin
            state_d = StChk;
          end
        end else begin
          held_d = rd_value_q;
          dly_d  = dly_q - 16'd1;
          state_d = StChk;
        end
      end
      StRdNx: begin
        dreq.start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (ddone) begin
          held_d = v0_q + dquo[15:0];
          segt_d = segt_q + 16'd1;
          state_d = StChk;
        end
      end
      StChk: begin
        if (segt_q >= rd_time_q) begin
          segt_d  = '0;
          seg_d   = nxt_seg;
          rd_addr = nxt_seg;
          state_d = StNxt;
        end else begin
          state_d = StFin;
        end
      end
      StNxt: begin
        if (rd_time_q == '0) begin
          seg_d = '0;
          dly_d = delay_cfg_q;
          if (rep_q != RepeatForever && rep_q != '0) rep_d = rep_q - 8'd1;
        end
        state_d = StFin;
      end
      StFin: begin
        if (!mode_q[0]) held_d = '0;
        out_d.dac_write = (lastw_q != held_d);
        lastw_d = held_d;
        held_d  = held_d;
        out_d.dac_code = held_d;
        out_d.range_out = rpin_q;
        out_d.ripple_low_phase = rlow_q;
        out_d.repeats_left = rep_q;
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      seg_q    <= '0;
      segt_q   <= '0;
      dly_q    <= '0;
      held_q   <= '0;
      lastw_q  <= 16'hffff;
      rep_q    <= '0;
      rrun_q   <= 1'b0;
      rlow_q   <= 1'b0;
      rpin_q   <= 1'b0;
      rcnt_q   <= '0;
      lrange_q <= 2'd3;
      rstage_q <= 3'd4;
      t0_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seg_q    <= seg_d;
      segt_q   <= segt_d;
      dly_q    <= dly_d;
      held_q   <= held_d;
      lastw_q  <= lastw_d;
      rep_q    <= rep_d;
      rrun_q   <= rrun_d;
      rlow_q   <= rlow_d;
      rpin_q   <= rpin_d;
      rcnt_q   <= rcnt_d;
      lrange_q <= lrange_d;
      rstage_q <= rstage_d;
      t0_q     <= t0_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q  <= v0_d;
    out_q <= out_d;
  end

  logic unused_inc;
  assign unused_inc = seg_inc[IdxW];

endmodule
